@@ rtl/tcalu_pkg.sv @@
// Shared types and codes for the typed checked integer ALU.
package tcalu_pkg;

   localparam int unsigned DATA_W     = 32;
   localparam int unsigned DIV_STAGES = 32;
   // Request to response strobe, in cycles after the accepting edge.
   localparam int unsigned PIPE_LATENCY = DIV_STAGES + 3;

   localparam logic [2:0] MODE_ADD = 3'd0;
   localparam logic [2:0] MODE_SUB = 3'd1;
   localparam logic [2:0] MODE_MUL = 3'd2;
   localparam logic [2:0] MODE_DIV = 3'd3;
   localparam logic [2:0] MODE_MOD = 3'd4;

   localparam logic [1:0] TYPE_INT8  = 2'd0;
   localparam logic [1:0] TYPE_INT16 = 2'd1;
   localparam logic [1:0] TYPE_INT32 = 2'd2;

   localparam logic [1:0] STATUS_OK      = 2'd0;
   localparam logic [1:0] STATUS_OVER    = 2'd1;
   localparam logic [1:0] STATUS_UNDER   = 2'd2;
   localparam logic [1:0] STATUS_DIVZERO = 2'd3;

   localparam logic signed [63:0] INT8_MIN  = -64'sd128;
   localparam logic signed [63:0] INT8_MAX  = 64'sd127;
   localparam logic signed [63:0] INT16_MIN = -64'sd32768;
   localparam logic signed [63:0] INT16_MAX = 64'sd32767;
   localparam logic signed [63:0] INT32_MIN = -64'sd2147483648;
   localparam logic signed [63:0] INT32_MAX = 64'sd2147483647;

   typedef struct packed {
      logic [2:0]               mode;
      logic [1:0]               left_type;
      logic signed [DATA_W-1:0] left_value;
      logic [1:0]               right_type;
      logic signed [DATA_W-1:0] right_value;
   } req_type;

   typedef struct packed {
      logic signed [DATA_W-1:0] result_value;
      logic [1:0]               result_type;
      logic [1:0]               status;
   } rsp_type;

endpackage

@@ rtl/typed_checked_integer_alu.sv @@
// Typed checked integer ALU: add, subtract, multiply, divide, modulo with range check.
// Every mode passes through the capture stage, the operand stage, the divider stages and the output register.
// Throughput: one request per cycle; busy is always low.
// The divider has 32 stages, one quotient bit per stage.
// Synchronous reset clears the valid bits of every stage; data registers are not reset.
// The receiver cannot stall; each response is shown for one cycle.
module typed_checked_integer_alu (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  tcalu_pkg::req_type    req_item,
   output logic                  rsp_strobe,
   output tcalu_pkg::rsp_type    rsp_item
);

   localparam int unsigned W = tcalu_pkg::DATA_W;
   localparam int unsigned N = tcalu_pkg::DIV_STAGES;

   typedef struct packed {
      logic [2:0]         mode;
      logic [1:0]         typ;
      logic signed [63:0] value;
      logic               neg_q;
      logic               neg_r;
      logic               zero;
   } side_type;

   // stage 1: capture request
   tcalu_pkg::req_type req_ff;
   logic               v1_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= start;
      end
   end

   always_ff @(posedge clock) begin
      req_ff <= req_item;
   end

   assign busy = 1'b0;

   // stage 2: add, subtract, multiply; operand magnitudes for the divider
   side_type     side2_in, side2_ff;
   logic         v2_ff;
   logic [W-1:0] dvd_in, dvd_ff, dsr_in, dsr_ff;
   logic [1:0]   lt, rt;
   logic signed [63:0] a64, b64, prod;

   always_comb begin
      lt  = (req_ff.left_type  == 2'd3) ? tcalu_pkg::TYPE_INT32 : req_ff.left_type;
      rt  = (req_ff.right_type == 2'd3) ? tcalu_pkg::TYPE_INT32 : req_ff.right_type;
      a64 = 64'(req_ff.left_value);
      b64 = 64'(req_ff.right_value);
      prod = req_ff.left_value * req_ff.right_value;
      side2_in.mode  = req_ff.mode;
      side2_in.typ   = (lt >= rt) ? lt : rt;
      side2_in.neg_q = req_ff.left_value[W-1] ^ req_ff.right_value[W-1];
      side2_in.neg_r = req_ff.left_value[W-1];
      side2_in.zero  = (req_ff.right_value == '0);
      case (req_ff.mode)
         tcalu_pkg::MODE_ADD: side2_in.value = a64 + b64;
         tcalu_pkg::MODE_SUB: side2_in.value = a64 - b64;
         tcalu_pkg::MODE_MUL: side2_in.value = prod;
         default:             side2_in.value = '0;
      endcase
      dvd_in = req_ff.left_value[W-1]  ? W'(-req_ff.left_value)  : W'(req_ff.left_value);
      dsr_in = req_ff.right_value[W-1] ? W'(-req_ff.right_value) : W'(req_ff.right_value);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      side2_ff <= side2_in;
      dvd_ff   <= dvd_in;
      dsr_ff   <= dsr_in;
   end

   // divider stages, with the sideband delayed alongside
   logic [W-1:0] quot, rem;

   tcalu_div u_div (
      .clock     (clock),
      .dividend  (dvd_ff),
      .divisor   (dsr_ff),
      .quotient  (quot),
      .remainder (rem)
   );

   side_type side_ff [N];
   logic     vd_ff   [N];

   for (genvar i = 0; i < N; i++) begin : g_line
      always_ff @(posedge clock) begin
         if (reset) begin
            vd_ff[i] <= 1'b0;
         end else begin
            vd_ff[i] <= (i == 0) ? v2_ff : vd_ff[(i == 0) ? 0 : i-1];
         end
      end
      always_ff @(posedge clock) begin
         side_ff[i] <= (i == 0) ? side2_ff : side_ff[(i == 0) ? 0 : i-1];
      end
   end

   // final stage: sign the divider results and check the range
   side_type           sd;
   logic signed [63:0] q64, r64, full, lo, hi;
   logic               is_div;
   tcalu_pkg::rsp_type rsp_in, rsp_ff;
   logic               vo_ff;

   always_comb begin
      sd     = side_ff[N-1];
      q64    = sd.neg_q ? -$signed({32'd0, quot}) : $signed({32'd0, quot});
      r64    = sd.neg_r ? -$signed({32'd0, rem})  : $signed({32'd0, rem});
      is_div = (sd.mode == tcalu_pkg::MODE_DIV) || (sd.mode == tcalu_pkg::MODE_MOD);
      case (sd.mode)
         tcalu_pkg::MODE_DIV: full = q64;
         tcalu_pkg::MODE_MOD: full = r64;
         default:             full = sd.value;
      endcase
      case (sd.typ)
         tcalu_pkg::TYPE_INT8: begin
            lo = tcalu_pkg::INT8_MIN;
            hi = tcalu_pkg::INT8_MAX;
         end
         tcalu_pkg::TYPE_INT16: begin
            lo = tcalu_pkg::INT16_MIN;
            hi = tcalu_pkg::INT16_MAX;
         end
         default: begin
            lo = tcalu_pkg::INT32_MIN;
            hi = tcalu_pkg::INT32_MAX;
         end
      endcase
      rsp_in.result_type = sd.typ;
      if (is_div && sd.zero) begin
         rsp_in.status = tcalu_pkg::STATUS_DIVZERO;
      end else if (full < lo) begin
         rsp_in.status = tcalu_pkg::STATUS_UNDER;
      end else if (full > hi) begin
         rsp_in.status = tcalu_pkg::STATUS_OVER;
      end else begin
         rsp_in.status = tcalu_pkg::STATUS_OK;
      end
      rsp_in.result_value = (rsp_in.status == tcalu_pkg::STATUS_OK) ? full[W-1:0] : '0;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vo_ff <= 1'b0;
      end else begin
         vo_ff <= vd_ff[N-1];
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff <= rsp_in;
   end

   assign rsp_strobe = vo_ff;
   assign rsp_item   = rsp_ff;

endmodule

@@ rtl/tcalu_div.sv @@
// Pipelined unsigned restoring divider, one quotient bit per stage.
module tcalu_div (
   input  logic                              clock,
   input  logic [tcalu_pkg::DATA_W-1:0]      dividend,
   input  logic [tcalu_pkg::DATA_W-1:0]      divisor,
   output logic [tcalu_pkg::DATA_W-1:0]      quotient,
   output logic [tcalu_pkg::DATA_W-1:0]      remainder
);

   localparam int unsigned W = tcalu_pkg::DATA_W;
   localparam int unsigned N = tcalu_pkg::DIV_STAGES;

   logic [W-1:0] rem_ff [N];
   logic [W-1:0] dvd_ff [N];
   logic [W-1:0] dsr_ff [N];

   for (genvar i = 0; i < N; i++) begin : g_stage
      logic [W-1:0] rem_prev;
      logic [W-1:0] dvd_prev;
      logic [W-1:0] dsr_prev;
      logic [W:0]   trial;
      logic [W:0]   diff;
      logic         fits;
      logic [W-1:0] rem_in;
      logic [W-1:0] dvd_in;

      if (i == 0) begin : g_first
         assign rem_prev = '0;
         assign dvd_prev = dividend;
         assign dsr_prev = divisor;
      end else begin : g_next
         assign rem_prev = rem_ff[i-1];
         assign dvd_prev = dvd_ff[i-1];
         assign dsr_prev = dsr_ff[i-1];
      end

      always_comb begin
         trial  = {rem_prev, dvd_prev[W-1]};
         diff   = trial - {1'b0, dsr_prev};
         fits   = (trial >= {1'b0, dsr_prev});
         rem_in = fits ? diff[W-1:0] : trial[W-1:0];
         // quotient bits shift in behind the dividend bits
         dvd_in = {dvd_prev[W-2:0], fits};
      end

      always_ff @(posedge clock) begin
         rem_ff[i] <= rem_in;
         dvd_ff[i] <= dvd_in;
         dsr_ff[i] <= dsr_prev;
      end
   end

   assign quotient  = dvd_ff[N-1];
   assign remainder = rem_ff[N-1];

endmodule

@@ rtl/tcalu_check.sv @@
// Port-level checks for the typed checked integer ALU, bound to the top level.
module tcalu_check (
   input logic               clock,
   input logic               reset,
   input logic               start,
   input logic               busy,
   input logic               rsp_strobe,
   input tcalu_pkg::rsp_type rsp_item
);

   a_no_busy: assert property (@(posedge clock) disable iff (reset) !busy)
      else $error("busy raised");

   a_beat_in_out: assert property (@(posedge clock) disable iff (reset)
      (start && !busy) |-> ##(tcalu_pkg::PIPE_LATENCY) rsp_strobe)
      else $error("accepted beat produced no response");

   a_no_invented: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, tcalu_pkg::PIPE_LATENCY))
      else $error("response without request");

   a_zero_on_fault: assert property (@(posedge clock) disable iff (reset)
      (rsp_strobe && rsp_item.status != tcalu_pkg::STATUS_OK)
         |-> (rsp_item.result_value == '0))
      else $error("faulted response carries a value");

   a_type_legal: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> (rsp_item.result_type != 2'd3))
      else $error("illegal result type");

endmodule

bind typed_checked_integer_alu tcalu_check u_tcalu_check (.*);
